[rtl/hbw_pkg.sv]
// Package: shared types and codes for the heartbeat watchdog.
`default_nettype none
package hbw_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 22;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIKE_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE_CLEAR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_PERIOD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEDUP        = 3'd4;

  localparam logic [19:0] TIMEOUT_RST      = 20'd5000;
  localparam logic [7:0]  STRIKE_LIMIT_RST = 8'd3;
  localparam logic [21:0] STABLE_CLEAR_RST = 22'd600000;
  localparam logic [15:0] POLL_PERIOD_RST  = 16'd1000;
  localparam logic [15:0] DEDUP_RST        = 16'd600;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_KICK  = 2'd1,
    REQ_BOOT  = 2'd2,
    REQ_LATCH = 2'd3
  } req_t;

  typedef struct packed {
    logic [19:0] hb_timeout;
    logic [7:0]  strike_limit;
    logic [21:0] stable_clear_ms;
    logic [15:0] poll_period_ms;
    logic [15:0] dedup_ms;
  } cfg_t;

  typedef struct packed {
    logic       restart_request;
    logic       fatal_request;
    logic       persist_request;
    logic [7:0] strike_count;
    logic       latched;
    logic       fatal_last_boot;
  } res_t;

endpackage
`default_nettype wire

[rtl/heartbeat_watchdog_strike_breaker.sv]
// Top level of the heartbeat watchdog with persistent strike count.
// Each input transfer (tick, heartbeat kick, boot or external latch) updates the
// watchdog state in the cycle it is taken and yields exactly one result, which
// appears in the output register in the next cycle. Unless stalled, one item is
// taken every cycle: the state update is a single pass of saturating counters and
// compares, and the output register accepts a new result in the cycle the old one
// transfers. Configuration writes are taken every cycle (cfg_ready is always high).
`default_nettype none
module heartbeat_watchdog_strike_breaker
  import hbw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic [1:0]            in_req_type,
  input  wire logic [7:0]            in_stored_strikes,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic                  out_restart_request,
  output      logic                  out_fatal_request,
  output      logic                  out_persist_request,
  output      logic [7:0]            out_strike_count,
  output      logic                  out_latched,
  output      logic                  out_fatal_last_boot,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  res_t res;
  res_t res_r;
  logic out_valid_r;
  logic in_xfer;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;

  hbw_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  hbw_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (in_xfer),
    .req_type       (in_req_type),
    .stored_strikes (in_stored_strikes),
    .cfg            (cfg),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_restart_request = res_r.restart_request;
  assign out_fatal_request   = res_r.fatal_request;
  assign out_persist_request = res_r.persist_request;
  assign out_strike_count    = res_r.strike_count;
  assign out_latched         = res_r.latched;
  assign out_fatal_last_boot = res_r.fatal_last_boot;

  a_restart_xor_fatal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_restart_request && out_fatal_request))
    else $error("restart and fatal requested together");

  a_fatal_latches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fatal_request |-> out_latched && out_persist_request)
    else $error("fatal request without latch or persist");

  a_restart_unlatched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_restart_request |-> !out_latched && out_persist_request)
    else $error("restart request while latched or without persist");

  a_result_follows_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid)
    else $error("accepted item left no result");

endmodule
`default_nettype wire

[rtl/hbw_cfg.sv]
// Configuration register file of the heartbeat watchdog.
`default_nettype none
module hbw_cfg
  import hbw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hb_timeout      <= TIMEOUT_RST;
      cfg_r.strike_limit    <= STRIKE_LIMIT_RST;
      cfg_r.stable_clear_ms <= STABLE_CLEAR_RST;
      cfg_r.poll_period_ms  <= POLL_PERIOD_RST;
      cfg_r.dedup_ms        <= DEDUP_RST;
    end else if (wr_en) begin
      case (wr_index)
        CFG_TIMEOUT:      cfg_r.hb_timeout      <= wr_data[19:0];
        CFG_STRIKE_LIMIT: cfg_r.strike_limit    <= wr_data[7:0];
        CFG_STABLE_CLEAR: cfg_r.stable_clear_ms <= wr_data[21:0];
        CFG_POLL_PERIOD:  cfg_r.poll_period_ms  <= wr_data[15:0];
        CFG_DEDUP:        cfg_r.dedup_ms        <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

[rtl/hbw_core.sv]
// Watchdog state and its per-event update logic.
`default_nettype none
module hbw_core
  import hbw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       en,
  input  wire logic [1:0] req_type,
  input  wire logic [7:0] stored_strikes,
  input  wire cfg_t       cfg,
  output res_t            res
);

  logic [20:0] kick_age_r,     kick_age_nxt;
  logic [21:0] boot_age_r,     boot_age_nxt;
  logic [15:0] since_r,        since_nxt;
  logic        seen_r,         seen_nxt;
  logic [7:0]  strikes_r,      strikes_nxt;
  logic        wclr_r,         wclr_nxt;
  logic        fatal_r,        fatal_nxt;
  logic        was_fatal_r,    was_fatal_nxt;
  logic [15:0] poll_r,         poll_nxt;

  logic [20:0] kick_inc;
  logic [21:0] boot_inc;
  logic [15:0] since_inc;
  logic [15:0] poll_inc;
  logic        poll_hit;
  logic        clear_hit;
  logic        strike_hit;
  logic [7:0]  strikes_base;
  logic [7:0]  strikes_inc;
  logic        limit_hit;
  logic        boot_lower;
  logic [7:0]  boot_count;
  req_t        req;

  assign req       = req_t'(req_type);
  assign kick_inc  = (kick_age_r == '1) ? kick_age_r : kick_age_r + 21'd1;
  assign boot_inc  = (boot_age_r == '1) ? boot_age_r : boot_age_r + 22'd1;
  assign since_inc = (since_r == '1) ? since_r : since_r + 16'd1;
  assign poll_inc  = poll_r + 16'd1;
  assign poll_hit  = (poll_inc >= cfg.poll_period_ms);

  assign clear_hit  = !wclr_r && (boot_inc >= cfg.stable_clear_ms);
  // no dedup before the first strike since boot
  assign strike_hit = (kick_inc > {1'b0, cfg.hb_timeout}) &&
                      !(seen_r && (since_inc < cfg.dedup_ms));
  assign strikes_base = clear_hit ? 8'd0 : strikes_r;
  assign strikes_inc  = (strikes_base == '1) ? strikes_base : strikes_base + 8'd1;
  assign limit_hit    = (strikes_inc >= cfg.strike_limit);

  assign boot_lower = (stored_strikes >= cfg.strike_limit);
  assign boot_count = !boot_lower ? stored_strikes :
                      (cfg.strike_limit != 8'd0) ? cfg.strike_limit - 8'd1 : 8'd0;

  always_comb begin
    kick_age_nxt  = kick_age_r;
    boot_age_nxt  = boot_age_r;
    since_nxt     = since_r;
    seen_nxt      = seen_r;
    strikes_nxt   = strikes_r;
    wclr_nxt      = wclr_r;
    fatal_nxt     = fatal_r;
    was_fatal_nxt = was_fatal_r;
    poll_nxt      = poll_r;
    res.restart_request = 1'b0;
    res.fatal_request   = 1'b0;
    res.persist_request = 1'b0;
    case (req)
      REQ_TICK: begin
        kick_age_nxt = kick_inc;
        boot_age_nxt = boot_inc;
        since_nxt    = since_inc;
        poll_nxt     = poll_inc;
        if (poll_hit) begin
          poll_nxt = '0;
          if (!fatal_r) begin
            if (clear_hit) begin
              strikes_nxt         = '0;
              wclr_nxt            = 1'b1;
              res.persist_request = 1'b1;
            end
            if (strike_hit) begin
              seen_nxt            = 1'b1;
              since_nxt           = '0;
              strikes_nxt         = strikes_inc;
              res.persist_request = 1'b1;
              if (limit_hit) begin
                fatal_nxt         = 1'b1;
                res.fatal_request = 1'b1;
              end else begin
                res.restart_request = 1'b1;
                kick_age_nxt        = '0;
              end
            end
          end
        end
      end
      REQ_KICK: begin
        if (!fatal_r) begin
          kick_age_nxt = '0;
        end
      end
      REQ_BOOT: begin
        kick_age_nxt        = '0;
        boot_age_nxt        = '0;
        since_nxt           = '0;
        seen_nxt            = 1'b0;
        poll_nxt            = '0;
        fatal_nxt           = 1'b0;
        strikes_nxt         = boot_count;
        was_fatal_nxt       = boot_lower;
        wclr_nxt            = (boot_count == 8'd0);
        res.persist_request = boot_lower;
      end
      REQ_LATCH: begin
        fatal_nxt = 1'b1;
      end
      default: ;
    endcase
    res.strike_count    = strikes_nxt;
    res.latched         = fatal_nxt;
    res.fatal_last_boot = was_fatal_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kick_age_r  <= '0;
      boot_age_r  <= '0;
      since_r     <= '0;
      seen_r      <= 1'b0;
      strikes_r   <= '0;
      wclr_r      <= 1'b1;
      fatal_r     <= 1'b0;
      was_fatal_r <= 1'b0;
      poll_r      <= '0;
    end else if (en) begin
      kick_age_r  <= kick_age_nxt;
      boot_age_r  <= boot_age_nxt;
      since_r     <= since_nxt;
      seen_r      <= seen_nxt;
      strikes_r   <= strikes_nxt;
      wclr_r      <= wclr_nxt;
      fatal_r     <= fatal_nxt;
      was_fatal_r <= was_fatal_nxt;
      poll_r      <= poll_nxt;
    end
  end

endmodule
`default_nettype wire
